@@ rtl/rsdm_pkg.sv @@
`timescale 1ns / 1ps

package rsdm_pkg;

  localparam int unsigned MaxPattern = 32;
  localparam int unsigned LenW       = 6;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned WordW      = 64;
  localparam int unsigned PatWords   = 4;
  localparam int unsigned CfgIdxW    = 3;

  localparam logic [ByteW-1:0] StarByte = 8'h2A;
  localparam logic [ByteW-1:0] DotByte  = 8'h2E;

  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLength  = 3'd0,
    CfgPatternBytes0  = 3'd1,
    CfgPatternBytes1  = 3'd2,
    CfgPatternBytes2  = 3'd3,
    CfgPatternBytes3  = 3'd4
  } cfg_idx_e;

  // Per-transaction control broadcast to every cell
  typedef struct packed {
    logic             take;
    logic             restart;
    logic             empty;
    logic [ByteW-1:0] ch;
  } rsdm_step_t;

endpackage

@@ rtl/rsdm_if.sv @@
`timescale 1ns / 1ps

interface rsdm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       first_of_text;
  logic       empty_text;

  modport source (output valid, text_byte, first_of_text, empty_text, input ready);
  modport sink   (input valid, text_byte, first_of_text, empty_text, output ready);
endinterface

interface rsdm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, matched, input ready);
  modport sink   (input valid, matched, output ready);
endinterface

interface rsdm_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/rsdm_cell.sv @@
`timescale 1ns / 1ps

module rsdm_cell
  import rsdm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  rsdm_step_t       step_i,
  input  logic             en_i,
  input  logic             star_ok_i,
  input  logic [ByteW-1:0] pat_i,
  input  logic [ByteW-1:0] pat_prev_i,
  input  logic             old_prev_i,
  input  logic             adv_prev2_i,
  input  logic             emp_prev2_i,
  output logic             old_o,
  output logic             adv_o,
  output logic             emp_o,
  output logic             nxt_o
);

  logic row_q, row_d;
  logic is_star, hit_cur, hit_prev, adv;

  assign is_star  = (pat_i == StarByte);
  assign hit_cur  = (pat_i == step_i.ch) || (pat_i == DotByte);
  assign hit_prev = (pat_prev_i == step_i.ch) || (pat_prev_i == DotByte);

  // Empty-string row: a star copies the bit two positions back
  assign emp_o = en_i & star_ok_i & is_star & emp_prev2_i;
  assign old_o = step_i.restart ? emp_o : row_q;

  // Star: skip the element pair, or repeat it; literal: extend the prefix
  assign adv   = is_star ? (star_ok_i & (adv_prev2_i | (old_o & hit_prev)))
                         : (old_prev_i & hit_cur);
  assign adv_o = en_i & adv;
  assign nxt_o = step_i.empty ? emp_o : adv_o;

  assign row_d = step_i.take ? nxt_o : row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= 1'b0;
    end else begin
      row_q <= row_d;
    end
  end

endmodule

@@ rtl/regex_star_dot_matcher.sv @@
`timescale 1ns / 1ps

// Streaming matcher for patterns of literal bytes, '.' and 'x*'.
// Load the pattern through cfg_i: index 0 sets the length, indices 1..4
// set pattern bytes 0..31, eight per write, lowest byte first. Write only
// while no result is pending. cfg_i never stalls.
// Each in_i transaction carries one text byte; first_of_text restarts the
// match for a new string, empty_text reports the empty-string match and
// consumes no byte. Every transaction gives exactly one out_o result:
// matched is set when the text since the last restart matches the whole
// pattern.
// The result is registered: out_o.valid rises in the cycle after acceptance.
// One transaction is accepted per cycle unless out_o stalls: a row of cells,
// one per pattern position, updates all prefix-match bits in the same cycle,
// with star positions rippling their bit two cells forward.
// A one-entry output register holds the result while out_o.ready is low;
// in_i stays ready as long as that register empties in the same cycle.
// Reset clears the pattern and leaves the row with only the empty prefix
// matched.
module regex_star_dot_matcher
  import rsdm_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = MaxPattern
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsdm_cfg_if.sink    cfg_i,
  rsdm_in_if.sink     in_i,
  rsdm_out_if.source  out_o
);

  localparam int unsigned IdxW = $clog2(MAX_PATTERN + 1);
  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_PATTERN);

  logic [LenW-1:0]                len_q, len_d;
  logic [PatWords-1:0][WordW-1:0] pat_q, pat_d;
  logic [PatWords*WordW-1:0]      pat_flat;
  logic [LenW-1:0]                len_used;

  logic                           row0_q, row0_d;
  logic                           out_valid_q, out_valid_d;
  logic                           matched_q, matched_d;

  rsdm_step_t                     step;
  logic [MAX_PATTERN:0]           old_row, adv_row, emp_row, nxt_row;
  logic                           cfg_take;

  // Configuration registers
  assign cfg_i.ready = 1'b1;
  assign cfg_take    = cfg_i.valid;

  always_comb begin
    len_d = len_q;
    pat_d = pat_q;
    if (cfg_take) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CfgPatternLength: len_d    = cfg_i.data[LenW-1:0];
        CfgPatternBytes0: pat_d[0] = cfg_i.data;
        CfgPatternBytes1: pat_d[1] = cfg_i.data;
        CfgPatternBytes2: pat_d[2] = cfg_i.data;
        CfgPatternBytes3: pat_d[3] = cfg_i.data;
        default: ;
      endcase
    end
  end

  assign pat_flat = pat_q;
  assign len_used = (len_q > MaxLen) ? MaxLen : len_q;

  // Input handshake and step control
  assign in_i.ready   = !out_valid_q || out_o.ready;
  assign step.take    = in_i.valid && in_i.ready;
  assign step.restart = in_i.first_of_text || in_i.empty_text;
  assign step.empty   = in_i.empty_text;
  assign step.ch      = in_i.text_byte;

  // Position zero: the empty prefix
  assign emp_row[0] = 1'b1;
  assign old_row[0] = step.restart ? 1'b1 : row0_q;
  assign adv_row[0] = 1'b0;
  assign nxt_row[0] = step.empty;
  assign row0_d     = step.take ? nxt_row[0] : row0_q;

  for (genvar j = 1; j <= MAX_PATTERN; j++) begin : g_cell
    logic             en;
    logic [ByteW-1:0] pat_prev;
    logic             adv_prev2, emp_prev2;

    assign en = (len_used >= LenW'(j));

    if (j >= 2) begin : g_inner
      assign pat_prev  = pat_flat[(j-2)*ByteW +: ByteW];
      assign adv_prev2 = adv_row[j-2];
      assign emp_prev2 = emp_row[j-2];
    end else begin : g_first
      assign pat_prev  = pat_flat[0 +: ByteW];
      assign adv_prev2 = 1'b0;
      assign emp_prev2 = 1'b0;
    end

    rsdm_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .step_i      (step),
      .en_i        (en),
      .star_ok_i   (j >= 2),
      .pat_i       (pat_flat[(j-1)*ByteW +: ByteW]),
      .pat_prev_i  (pat_prev),
      .old_prev_i  (old_row[j-1]),
      .adv_prev2_i (adv_prev2),
      .emp_prev2_i (emp_prev2),
      .old_o       (old_row[j]),
      .adv_o       (adv_row[j]),
      .emp_o       (emp_row[j]),
      .nxt_o       (nxt_row[j])
    );
  end

  // Output register: load on a new transaction, hold while stalled
  assign out_valid_d = step.take || (out_valid_q && !out_o.ready);
  assign matched_d   = step.take ? nxt_row[len_used[IdxW-1:0]] : matched_q;

  assign out_o.valid   = out_valid_q;
  assign out_o.matched = matched_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      pat_q       <= '0;
      row0_q      <= 1'b1;
      out_valid_q <= 1'b0;
      matched_q   <= 1'b0;
    end else begin
      len_q       <= len_d;
      pat_q       <= pat_d;
      row0_q      <= row0_d;
      out_valid_q <= out_valid_d;
      matched_q   <= matched_d;
    end
  end

`ifndef SYNTHESIS
  a_take_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.take |=> out_o.valid)
    else $error("accepted transaction produced no result");

  a_stall_holds_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready && !step.take |=> out_o.valid && $stable(out_o.matched))
    else $error("stalled result changed");

  a_byte_clears_prefix0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.take && !step.empty |=> !row0_q)
    else $error("empty prefix still set after a consumed byte");

  a_zero_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step.take && (len_used == '0) |=> out_o.matched == $past(in_i.empty_text))
    else $error("zero-length pattern result wrong");
`endif

endmodule

@@ dv/rsdm_match_checker.sv @@
`timescale 1ns / 1ps

module rsdm_match_checker
  import rsdm_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  rsdm_cfg_if  cfg_mon,
  rsdm_in_if   text_mon,
  rsdm_out_if  result_mon,
  output int   failures_o,
  output int   pending_o
);

  localparam int unsigned BytesPerWord = WordW / ByteW;

  logic [LenW-1:0]     length_reg;
  logic [WordW-1:0]    pattern_word [PatWords];
  logic [MaxPattern:0] prefix_row;
  logic                expected_match_q [$];

  function automatic logic [ByteW-1:0] pattern_byte(int unsigned pos);
    return pattern_word[pos / BytesPerWord][(pos % BytesPerWord) * ByteW +: ByteW];
  endfunction

  function automatic int unsigned used_length();
    return (length_reg > MaxPattern) ? MaxPattern : int'(length_reg);
  endfunction

  function automatic logic elem_hit(logic [ByteW-1:0] elem, logic [ByteW-1:0] ch);
    return (elem == ch) || (elem == DotByte);
  endfunction

  // Row for the empty string: a star lets its prefix skip the starred element
  function automatic logic [MaxPattern:0] restart_row(int unsigned n);
    logic [MaxPattern:0] row;
    row    = '0;
    row[0] = 1'b1;
    for (int unsigned j = 2; j <= n; j++) begin
      if (pattern_byte(j - 1) == StarByte && row[j - 2]) begin
        row[j] = 1'b1;
      end
    end
    return row;
  endfunction

  function automatic logic [MaxPattern:0] consume_byte(logic [MaxPattern:0] prev,
                                                       int unsigned n,
                                                       logic [ByteW-1:0] ch);
    logic [MaxPattern:0] row;
    logic [ByteW-1:0]    pb;
    row = '0;
    for (int unsigned j = 1; j <= n; j++) begin
      pb = pattern_byte(j - 1);
      if (pb == StarByte) begin
        // zero copies of the element, or one more copy on top of a match; a leading
        // star stays clear
        if (j >= 2) begin
          row[j] = row[j - 2] || (prev[j] && elem_hit(pattern_byte(j - 2), ch));
        end
      end else begin
        row[j] = prev[j - 1] && elem_hit(pb, ch);
      end
    end
    return row;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [MaxPattern:0] row_next;
    int unsigned         n;
    logic                exp_match;
    if (!rst_ni) begin
      length_reg   = '0;
      pattern_word = '{default: '0};
      prefix_row   = '0;
      prefix_row[0] = 1'b1;
      expected_match_q.delete();
      failures_o   = 0;
      pending_o    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index) inside
          CfgPatternLength: length_reg = cfg_mon.data[LenW-1:0];
          CfgPatternBytes0, CfgPatternBytes1, CfgPatternBytes2, CfgPatternBytes3: begin
            pattern_word[cfg_mon.index - CfgPatternBytes0] = cfg_mon.data;
          end
          default: ;
        endcase
      end

      if (text_mon.valid && text_mon.ready) begin
        n        = used_length();
        row_next = prefix_row;
        if (text_mon.first_of_text || text_mon.empty_text) begin
          row_next = restart_row(n);
        end
        if (!text_mon.empty_text) begin
          row_next = consume_byte(row_next, n, text_mon.text_byte);
        end
        prefix_row = row_next;
        expected_match_q.push_back(row_next[n]);
      end

      if (result_mon.valid && result_mon.ready) begin
        if (expected_match_q.size() == 0) begin
          $error("matched: expected no transaction, actual %0b", result_mon.matched);
          failures_o++;
        end else begin
          exp_match = expected_match_q.pop_front();
          if (result_mon.matched !== exp_match) begin
            $error("matched: expected %0b, actual %0b", exp_match, result_mon.matched);
            failures_o++;
          end
        end
      end

      pending_o = expected_match_q.size();
    end
  end

endmodule

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import rsdm_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int Phases     = 12;
  localparam int PhaseItems = 100;

  logic clk_i;
  logic rst_ni;
  int   failures;
  int   pending;
  int   items_sent = 0;
  int   cycle_count = 0;
  bit   gap_on = 1'b0;
  bit   stall_on = 1'b0;

  logic [ByteW-1:0] pattern_buf [MaxPattern];
  logic [ByteW-1:0] elem_char [$];
  bit               elem_star [$];

  rsdm_cfg_if cfg_if ();
  rsdm_in_if  in_if ();
  rsdm_out_if out_if ();

  regex_star_dot_matcher dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  rsdm_match_checker u_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_mon    (cfg_if),
    .text_mon   (in_if),
    .result_mon (out_if),
    .failures_o (failures),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: stall in bursts while enabled
  initial begin
    int stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        out_if.ready <= 1'b0;
        stall_left--;
      end else if (stall_on && $urandom_range(0, 4) == 0) begin
        out_if.ready <= 1'b0;
        stall_left = $urandom_range(1, 8) - 1;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  function automatic logic [ByteW-1:0] pick_letter();
    return "a" + 8'($urandom_range(0, 2));
  endfunction

  function automatic logic [ByteW-1:0] pick_text_byte();
    case ($urandom_range(0, 5))
      0:       return 8'($urandom);
      1:       return StarByte;
      2:       return DotByte;
      default: return pick_letter();
    endcase
  endfunction

  task automatic send_text(logic [ByteW-1:0] ch, logic first, logic empty);
    in_if.valid         <= 1'b1;
    in_if.text_byte     <= ch;
    in_if.first_of_text <= first;
    in_if.empty_text    <= empty;
    do @(posedge clk_i); while (!in_if.ready);
    items_sent++;
    @(negedge clk_i);
    if (gap_on && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
  endtask

  task automatic write_register(logic [CfgIdxW-1:0] idx, logic [WordW-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Drop valid and hold until every match result is back
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic load_pattern(int len, bit spare_write);
    logic [WordW-1:0] word;
    word            = {$urandom, $urandom};
    word[LenW-1:0]  = len[LenW-1:0];
    write_register(CfgPatternLength, word);
    for (int w = 0; w < PatWords; w++) begin
      for (int b = 0; b < WordW / ByteW; b++) begin
        word[b * ByteW +: ByteW] = pattern_buf[w * (WordW / ByteW) + b];
      end
      write_register(CfgIdxW'(CfgPatternBytes0 + w), word);
    end
    // indices past the last register must be dropped by the block
    if (spare_write || $urandom_range(0, 1) == 0) begin
      write_register(CfgIdxW'($urandom_range((1 << CfgIdxW) - 1, CfgPatternBytes3 + 1)),
                     {$urandom, $urandom});
    end
  endtask

  task automatic fill_pattern(string s);
    for (int i = 0; i < MaxPattern; i++) begin
      pattern_buf[i] = (i < s.len()) ? s[i] : pick_letter();
    end
  endtask

  task automatic build_random_pattern(int max_bytes, output int total);
    logic [ByteW-1:0] ch;
    elem_char.delete();
    elem_star.delete();
    total = 0;
    while (total < max_bytes) begin
      ch = ($urandom_range(0, 3) == 0) ? DotByte : pick_letter();
      pattern_buf[total] = ch;
      elem_char.push_back(ch);
      if ($urandom_range(0, 9) < 5 || total + 2 > max_bytes) begin
        elem_star.push_back(1'b0);
        total += 1;
      end else begin
        pattern_buf[total + 1] = StarByte;
        elem_star.push_back(1'b1);
        total += 2;
      end
    end
    for (int i = total; i < MaxPattern; i++) begin
      case ($urandom_range(0, 3))
        0:       pattern_buf[i] = DotByte;
        1:       pattern_buf[i] = StarByte;
        default: pattern_buf[i] = pick_letter();
      endcase
    end
    // star a random spot now and then, maybe leading or after another star
    if (total > 0 && $urandom_range(0, 5) == 0) begin
      pattern_buf[$urandom_range(0, total - 1)] = StarByte;
    end
  endtask

  // Mostly strings drawn from the pattern's own elements, the rest noise
  task automatic send_random_string();
    logic [ByteW-1:0] text [$];
    int               reps;
    if (elem_char.size() == 0 || $urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(0, 8)) text.push_back(pick_text_byte());
    end else begin
      foreach (elem_char[i]) begin
        reps = elem_star[i] ? $urandom_range(0, 3) : 1;
        repeat (reps) begin
          text.push_back((elem_char[i] == DotByte) ? pick_text_byte() : elem_char[i]);
        end
      end
      if (text.size() > 0 && $urandom_range(0, 4) == 0) begin
        text[$urandom_range(0, text.size() - 1)] = pick_letter();
      end
    end
    if (text.size() == 0) begin
      send_text(8'($urandom), 1'($urandom), 1'b1);
    end else begin
      foreach (text[i]) begin
        send_text(text[i], (i == 0) && ($urandom_range(0, 19) != 0), 1'b0);
      end
    end
  endtask

  initial begin
    int total;
    int len;
    int start;
    rst_ni              = 1'b0;
    in_if.valid         = 1'b0;
    in_if.text_byte     = '0;
    in_if.first_of_text = 1'b0;
    in_if.empty_text    = 1'b0;
    cfg_if.valid        = 1'b0;
    cfg_if.index        = CfgPatternLength;
    cfg_if.data         = '0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Star pattern fed before any restart, then the usual restarts
    fill_pattern("a*");
    load_pattern(2, 1'b1);
    send_text("a", 1'b0, 1'b0);
    send_text("a", 1'b0, 1'b1);
    send_text("a", 1'b1, 1'b0);
    send_text("a", 1'b0, 1'b0);
    send_text("b", 1'b0, 1'b0);
    wait_idle();

    // Leading star
    fill_pattern("*a");
    load_pattern(2, 1'b0);
    send_text("a", 1'b0, 1'b1);
    send_text("a", 1'b1, 1'b0);
    send_text(StarByte, 1'b1, 1'b0);
    wait_idle();

    // Star after star repeats a literal star
    fill_pattern("a**");
    load_pattern(3, 1'b0);
    send_text("a", 1'b1, 1'b0);
    send_text(StarByte, 1'b0, 1'b0);
    send_text(StarByte, 1'b0, 1'b0);
    send_text("b", 1'b0, 1'b0);
    wait_idle();

    // Length register past the maximum, full-width pattern
    fill_pattern(".*.*.*.*.*.*.*.*.*.*.*.*.*.*.*.*");
    load_pattern((1 << LenW) - 1, 1'b0);
    send_text(8'h00, 1'b1, 1'b0);
    send_text(8'hFF, 1'b0, 1'b0);
    send_text(8'hFF, 1'b1, 1'b1);
    wait_idle();

    // Empty pattern
    fill_pattern("");
    load_pattern(0, 1'b0);
    send_text(8'h55, 1'b0, 1'b1);
    send_text(8'h55, 1'b1, 1'b0);
    send_text(8'hAA, 1'b0, 1'b0);
    wait_idle();

    for (int phase = 0; phase < Phases; phase++) begin
      gap_on   = (phase < Phases - 2) && ($urandom_range(0, 3) != 0);
      stall_on = (phase < Phases - 2) && ($urandom_range(0, 3) != 0);
      case (phase)
        0: begin
          build_random_pattern(0, total);
          len = 0;
        end
        1: begin
          build_random_pattern(MaxPattern, total);
          len = $urandom_range(MaxPattern + 1, (1 << LenW) - 1);
        end
        2: begin
          build_random_pattern(MaxPattern, total);
          len = total;
        end
        default: begin
          build_random_pattern(($urandom_range(0, 4) == 0) ? $urandom_range(11, MaxPattern)
                                                           : $urandom_range(1, 10), total);
          len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, (1 << LenW) - 1) : total;
        end
      endcase
      load_pattern(len, 1'b0);
      start = items_sent;
      while (items_sent - start < PhaseItems) send_random_string();
      wait_idle();
    end

    repeat (8) @(negedge clk_i);
    if (failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
